// ===== rtl/clamped_pid_speed_loop_top_defines.svh =====
// Assertion macros shared by the speed loop RTL.
`ifndef CLAMPED_PID_SPEED_LOOP_TOP_DEFINES_SVH
`define CLAMPED_PID_SPEED_LOOP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define CPSL_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpsl assertion failed");
`define CPSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpsl assertion failed");
`else
`define CPSL_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define CPSL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/cpsl_pkg.sv =====
// Types and constants of the clamped PID speed loop.
`default_nettype none
package cpsl_pkg;

   localparam int GAIN_W  = 16;
   localparam int SPEED_W = 16;
   localparam int ERR_W   = 10;
   localparam int INTEG_W = 12;
   localparam int DIFF_W  = 11;
   localparam int DRIVE_W = 19;
   localparam int CSR_IDX_W = 2;

   localparam logic signed [ERR_W-1:0]   ERR_MAX   = 10'sd300;
   localparam logic signed [ERR_W-1:0]   ERR_MIN   = -10'sd300;
   localparam logic signed [INTEG_W-1:0] INTEG_MAX = 12'sd2000;
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = -12'sd2000;

   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 19'sh3FFFF;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 19'sh40000;

   // floor(y / 10) == (y * RECIP10) >> RECIP10_SHIFT for y < 2**22
   localparam logic [19:0] RECIP10       = 20'd838861;
   localparam int          RECIP10_SHIFT = 23;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P = 2'd0,
      CSR_GAIN_I = 2'd1,
      CSR_GAIN_D = 2'd2
   } csr_index_type;

endpackage
`default_nettype wire

// ===== rtl/clamped_pid_speed_loop_top.sv =====
// Clamped positional PID speed loop, five register stages.
// One drive value per tick: error = target - measured clamped to +-300, integral
// of clamped errors clamped to +-2000, drive = P + I/10 + D with Q7.8 gains, each
// term truncated toward zero, sum saturated to 19 bits signed. An item can be
// accepted every cycle unless the output stalls; it passes through the input,
// error/state, product, term and output registers in turn. Each stage has its
// own valid bit, so a stalled output only backs up through full stages. Gains
// come from csr writes the user must make only while the loop is idle; unchecked.
`default_nettype none
`include "clamped_pid_speed_loop_top_defines.svh"
module clamped_pid_speed_loop_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [cpsl_pkg::SPEED_W-1:0]  req_target_speed,
   input  wire logic        [cpsl_pkg::SPEED_W-1:0]  req_measured_speed,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [cpsl_pkg::DRIVE_W-1:0]       rsp_drive_value,
   input  wire logic                                 csr_write_enable,
   input  wire logic [cpsl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [cpsl_pkg::GAIN_W-1:0]          csr_write_data
);

   // config
   logic signed [cpsl_pkg::GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;

   // stage valids and handshakes
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic ld1, ld2, ld3, ld4, ld5;

   // stage 1: input register
   logic signed [cpsl_pkg::SPEED_W-1:0] target_ff;
   logic        [cpsl_pkg::SPEED_W-1:0] measured_ff;

   // loop state
   logic signed [cpsl_pkg::ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [cpsl_pkg::INTEG_W-1:0] integ_ff, integ_in;

   // stage 2
   logic signed [17:0]                  raw_err;
   logic signed [cpsl_pkg::INTEG_W:0]   integ_sum;
   logic signed [cpsl_pkg::ERR_W-1:0]   err_ff;
   logic signed [cpsl_pkg::INTEG_W-1:0] integ_s2_ff;
   logic signed [cpsl_pkg::DIFF_W-1:0]  diff_ff, diff_in;

   // stage 3
   logic signed [25:0] prod_p_ff, prod_p_in;
   logic signed [27:0] prod_i_ff, prod_i_in;
   logic signed [26:0] prod_d_ff, prod_d_in;

   // stage 4
   logic signed [25:0] adj_p;
   logic signed [26:0] adj_d;
   logic        [27:0] mag_i;
   logic        [39:0] quot_full;
   logic        [16:0] quot_i;
   logic signed [17:0] p_term_ff, p_term_in;
   logic signed [17:0] i_term_ff, i_term_in;
   logic signed [18:0] d_term_ff, d_term_in;

   // stage 5
   logic signed [19:0]                  sum;
   logic signed [cpsl_pkg::DRIVE_W-1:0] drive_ff, drive_in;

   // ready chain
   assign rdy5 = !v5_ff || rsp_ready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign ld1  = req_valid && rdy1;
   assign ld2  = v1_ff && rdy2;
   assign ld3  = v2_ff && rdy3;
   assign ld4  = v3_ff && rdy4;
   assign ld5  = v4_ff && rdy5;

   assign req_ready       = rdy1;
   assign rsp_valid       = v5_ff;
   assign rsp_drive_value = drive_ff;

   // error, integral, difference
   always_comb begin
      raw_err = {{2{target_ff[cpsl_pkg::SPEED_W-1]}}, target_ff} - {2'b00, measured_ff};
      if (raw_err > cpsl_pkg::ERR_MAX) begin
         prev_err_in = cpsl_pkg::ERR_MAX;
      end else if (raw_err < cpsl_pkg::ERR_MIN) begin
         prev_err_in = cpsl_pkg::ERR_MIN;
      end else begin
         prev_err_in = raw_err[cpsl_pkg::ERR_W-1:0];
      end
      integ_sum = (cpsl_pkg::INTEG_W+1)'(integ_ff) + (cpsl_pkg::INTEG_W+1)'(prev_err_in);
      if (integ_sum > cpsl_pkg::INTEG_MAX) begin
         integ_in = cpsl_pkg::INTEG_MAX;
      end else if (integ_sum < cpsl_pkg::INTEG_MIN) begin
         integ_in = cpsl_pkg::INTEG_MIN;
      end else begin
         integ_in = integ_sum[cpsl_pkg::INTEG_W-1:0];
      end
      diff_in = cpsl_pkg::DIFF_W'(prev_err_in) - cpsl_pkg::DIFF_W'(prev_err_ff);
   end

   // products
   assign prod_p_in = gain_p_ff * err_ff;
   assign prod_i_in = gain_i_ff * integ_s2_ff;
   assign prod_d_in = gain_d_ff * diff_ff;

   // terms, truncated toward zero
   always_comb begin
      adj_p     = prod_p_ff + {18'd0, {8{prod_p_ff[25]}}};
      adj_d     = prod_d_ff + {19'd0, {8{prod_d_ff[26]}}};
      p_term_in = adj_p[25:8];
      d_term_in = adj_d[26:8];
      mag_i     = prod_i_ff[27] ? 28'(-prod_i_ff) : 28'(prod_i_ff);
      quot_full = mag_i[27:8] * cpsl_pkg::RECIP10;
      quot_i    = quot_full[39:cpsl_pkg::RECIP10_SHIFT];
      i_term_in = prod_i_ff[27] ? -signed'({1'b0, quot_i}) : signed'({1'b0, quot_i});
   end

   // sum and saturate
   always_comb begin
      sum = 20'(p_term_ff) + 20'(i_term_ff) + 20'(d_term_ff);
      if (sum > cpsl_pkg::DRIVE_MAX) begin
         drive_in = cpsl_pkg::DRIVE_MAX;
      end else if (sum < cpsl_pkg::DRIVE_MIN) begin
         drive_in = cpsl_pkg::DRIVE_MIN;
      end else begin
         drive_in = sum[cpsl_pkg::DRIVE_W-1:0];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         v5_ff       <= 1'b0;
         prev_err_ff <= '0;
         integ_ff    <= '0;
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (ld2) begin
            prev_err_ff <= prev_err_in;
            integ_ff    <= integ_in;
         end
         if (csr_write_enable) begin
            case (csr_index)
               cpsl_pkg::CSR_GAIN_P: gain_p_ff <= csr_write_data;
               cpsl_pkg::CSR_GAIN_I: gain_i_ff <= csr_write_data;
               cpsl_pkg::CSR_GAIN_D: gain_d_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ld1) begin
         target_ff   <= req_target_speed;
         measured_ff <= req_measured_speed;
      end
      if (ld2) begin
         err_ff      <= prev_err_in;
         integ_s2_ff <= integ_in;
         diff_ff     <= diff_in;
      end
      if (ld3) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
      if (ld4) begin
         p_term_ff <= p_term_in;
         i_term_ff <= i_term_in;
         d_term_ff <= d_term_in;
      end
      if (ld5) begin
         drive_ff <= drive_in;
      end
   end

   `CPSL_ASSERT_IMPLIES(a_err_range, clock, reset, 1'b1,
      (prev_err_ff <= cpsl_pkg::ERR_MAX) && (prev_err_ff >= cpsl_pkg::ERR_MIN))
   `CPSL_ASSERT_IMPLIES(a_integ_range, clock, reset, 1'b1,
      (integ_ff <= cpsl_pkg::INTEG_MAX) && (integ_ff >= cpsl_pkg::INTEG_MIN))
   `CPSL_ASSERT_NEXT(a_state_holds, clock, reset, !ld2,
      $stable(prev_err_ff) && $stable(integ_ff))
   `CPSL_ASSERT_IMPLIES(a_out_from_s4, clock, reset, $rose(v5_ff), $past(v4_ff))

endmodule
`default_nettype wire
